// ----- src/cpx_pkg.sv -----
// shared types, constants and the colour repack function for the clut pixel expander
// no dependencies; imported by every module of the block
package cpx_pkg;

  // palette geometry
  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = 9;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 9;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_MODE    = 1'b0,
    CFG_PALETTE_COUNT = 1'b1
  } cfg_reg_e;

  // pixel packing mode
  typedef enum logic {
    MODE_4BPP = 1'b0,
    MODE_8BPP = 1'b1
  } pixel_mode_e;

  // request operation codes
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  // command kinds passed from front to back
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_ERROR = 2'd1,
    CMD_PIXEL = 2'd2
  } cmd_kind_e;

  // input request payload
  typedef struct packed {
    logic        operation;
    logic [7:0]  pixel_byte;
    logic [7:0]  entry_index;
    logic [15:0] entry_colour;
  } in_t;

  // result payload
  typedef struct packed {
    logic [15:0] pixel_colour;
    logic        index_error;
    logic        last_of_run;
  } out_t;

  // classified command
  typedef struct packed {
    cmd_kind_e   kind;
    logic        two;     // two lookups (4bpp byte)
    logic [7:0]  idx0;    // first index, or entry index for a write
    logic [7:0]  idx1;    // second index
    logic [15:0] colour;  // raw colour for a write
  } cmd_t;

  // back-end status seen by the top level
  typedef struct packed {
    logic mid_pair;  // first half of a 4bpp byte issued, second pending
    logic s1_valid;  // lookup stage occupied
  } back_status_t;

  // {stp, B5, G5, R5} to RRRRRGGGGGBBBBBA
  function automatic logic [15:0] repack(input logic [15:0] raw);
    logic [14:0] rgb;
    logic        black;
    logic        alpha;
    rgb   = {raw[4:0], raw[9:5], raw[14:10]};
    black = (rgb == 15'd0);
    alpha = (black == raw[15]);
    return {rgb, alpha};
  endfunction

endpackage

// ----- src/cpx_front.sv -----
// front end: configuration registers and classification of incoming requests
// depends on cpx_pkg
module cpx_front import cpx_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output cmd_t                  push_cmd_o
);

  pixel_mode_e      mode_q, mode_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] cnt_eff;
  logic [3:0]       nib_lo, nib_hi;
  logic             err;
  logic             write_ok;
  logic             accept;

  // configuration writes
  always_comb begin
    mode_d  = mode_q;
    count_d = count_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_PIXEL_MODE:    mode_d  = pixel_mode_e'(cfg_data_i[0]);
        CFG_PALETTE_COUNT: count_d = cfg_data_i[CNT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_4BPP;
      count_q <= '0;
    end else begin
      mode_q  <= mode_d;
      count_q <= count_d;
    end
  end

  // count clamped to the palette depth
  assign cnt_eff = (count_q > CNT_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH) : count_q;

  // index range check
  assign nib_lo = in_data_i.pixel_byte[3:0];
  assign nib_hi = in_data_i.pixel_byte[7:4];
  always_comb begin
    unique case (mode_q)
      MODE_8BPP: err = (CNT_W'(in_data_i.pixel_byte) >= cnt_eff);
      MODE_4BPP: err = (CNT_W'(nib_lo) >= cnt_eff) || (CNT_W'(nib_hi) >= cnt_eff);
    endcase
  end

  // writes beyond the palette are dropped
  assign write_ok = (CNT_W'(in_data_i.entry_index) < CNT_W'(PALETTE_DEPTH));

  // build the command
  always_comb begin
    push_cmd_o.two    = 1'b0;
    push_cmd_o.idx0   = in_data_i.entry_index;
    push_cmd_o.idx1   = 8'd0;
    push_cmd_o.colour = in_data_i.entry_colour;
    if (op_e'(in_data_i.operation) == OP_WRITE) begin
      push_cmd_o.kind = CMD_WRITE;
    end else if (err) begin
      push_cmd_o.kind = CMD_ERROR;
    end else begin
      push_cmd_o.kind = CMD_PIXEL;
      if (mode_q == MODE_8BPP) begin
        push_cmd_o.idx0 = in_data_i.pixel_byte;
      end else begin
        push_cmd_o.two  = 1'b1;
        push_cmd_o.idx0 = {4'd0, nib_lo};
        push_cmd_o.idx1 = {4'd0, nib_hi};
      end
    end
  end

  // handshake
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept &&
                      !((op_e'(in_data_i.operation) == OP_WRITE) && !write_ok);

endmodule

// ----- src/cpx_queue.sv -----
// two-entry command queue between the front and back ends
// depends on cpx_pkg
module cpx_queue import cpx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t head_o,
  input  logic pop_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

endmodule

// ----- src/cpx_back.sv -----
// back end: palette memory, lookup sequencer and result register
// depends on cpx_pkg
module cpx_back import cpx_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  cmd_t         q_head_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output out_t         out_data_o,
  output back_status_t status_o
);

  logic [15:0] palette_mem [PALETTE_DEPTH];

  logic             sub_q, sub_d;
  logic             s1_valid_q, s1_valid_d;
  logic             s1_err_q, s1_err_d;
  logic             s1_last_q, s1_last_d;
  logic [15:0]      s1_raw_q;
  logic             out_valid_q, out_valid_d;
  out_t             out_data_q, out_data_d;
  logic             out_can, s1_adv;
  logic             mem_we, rd_en;
  logic [IDX_W-1:0] rd_addr;

  assign out_can = !out_valid_q || !out_stall_i;
  assign s1_adv  = !s1_valid_q || out_can;

  // issue one operation per cycle from the queue head while the lookup stage can advance
  always_comb begin
    q_pop_o    = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = q_head_i.idx0[IDX_W-1:0];
    sub_d      = sub_q;
    s1_valid_d = s1_valid_q;
    s1_err_d   = s1_err_q;
    s1_last_d  = s1_last_q;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
      if (q_valid_i) begin
        unique case (q_head_i.kind)
          CMD_WRITE: begin
            mem_we  = 1'b1;
            q_pop_o = 1'b1;
          end
          CMD_ERROR: begin
            s1_valid_d = 1'b1;
            s1_err_d   = 1'b1;
            s1_last_d  = 1'b1;
            q_pop_o    = 1'b1;
          end
          CMD_PIXEL: begin
            rd_en      = 1'b1;
            s1_valid_d = 1'b1;
            s1_err_d   = 1'b0;
            if (q_head_i.two && !sub_q) begin
              s1_last_d = 1'b0;
              sub_d     = 1'b1;
            end else begin
              if (q_head_i.two) begin
                rd_addr = q_head_i.idx1[IDX_W-1:0];
              end
              s1_last_d = 1'b1;
              sub_d     = 1'b0;
              q_pop_o   = 1'b1;
            end
          end
          default: begin
            q_pop_o = 1'b1;
          end
        endcase
      end
    end
  end

  // palette memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      palette_mem[q_head_i.idx0[IDX_W-1:0]] <= q_head_i.colour;
    end
    if (rd_en) begin
      s1_raw_q <= palette_mem[rd_addr];
    end
  end

  // lookup stage tags
  always_ff @(posedge clk_i) begin
    s1_err_q  <= s1_err_d;
    s1_last_q <= s1_last_d;
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_can) begin
      out_valid_d = s1_valid_q;
      if (s1_err_q) begin
        out_data_d = '{pixel_colour: 16'd0, index_error: 1'b1, last_of_run: 1'b1};
      end else begin
        out_data_d = '{pixel_colour: repack(s1_raw_q), index_error: 1'b0,
                       last_of_run: s1_last_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sub_q       <= sub_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;
  assign status_o.mid_pair = sub_q;
  assign status_o.s1_valid = s1_valid_q;

endmodule

// ----- src/clut_pixel_expander_rgb5a1_core.sv -----
// top level of the clut pixel expander: front end, command queue, back end
// depends on cpx_pkg, cpx_front, cpx_queue and cpx_back
//
// Expands indexed pixel bytes through a 16-bit palette into RGB5A1 colours.
// Requests carry either a palette write (no result) or a pixel byte; in 8bpp
// mode a byte gives one colour, in 4bpp mode the low then the high nibble
// gives two, and a byte with any index at or above the palette count gives a
// single error result. The back end's palette memory has one lookup per
// cycle, so results leave at one per cycle unless the result side stalls;
// a 4bpp byte takes two lookups. An accepted request passes the command
// queue, the memory read and the result register before its result is
// presented. A two-entry queue takes requests while the result side stalls,
// until it is full. Configuration must only be written while the block is
// idle. Palette entries read before being written return unspecified colours.
module clut_pixel_expander_rgb5a1_core import cpx_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o
);

  logic         q_full, q_valid, q_push, q_pop;
  cmd_t         push_cmd, head_cmd;
  back_status_t back_status;

  // classification
  cpx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .push_cmd_o (push_cmd)
  );

  // command queue
  cpx_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (head_cmd),
    .pop_i      (q_pop)
  );

  // lookup and result
  cpx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (head_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .status_o    (back_status)
  );

  // error results are single, final and colourless
  a_error_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.index_error) |->
      (out_data_o.last_of_run && (out_data_o.pixel_colour == 16'd0)))
    else $error("error result not final or not zero");

  // a 4bpp byte stays at the queue head until its second half issues
  a_pair_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.mid_pair |-> q_valid)
    else $error("second half of pair lost from queue");

  // while a pair is split, its first colour sits in the lookup stage
  a_pair_first_in_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.mid_pair |-> back_status.s1_valid)
    else $error("first half of pair missing from lookup stage");

  // the second colour of a pair follows directly after the first is taken
  a_pair_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last_of_run) |=> out_valid_o)
    else $error("gap inside a pixel pair");

  // no pop without a queued command
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

// ----- dv/cpx_checker.sv -----
`timescale 1ns / 100ps
// result checker for the clut pixel expander: snoops config writes and both channels
// depends on cpx_pkg; instantiated next to the block by the testbench top
module cpx_checker import cpx_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_t                   in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_t                  out_data_i,
  output int                    mismatch_count_o,
  output int                    colours_owed_o
);

  // shadow of the palette and the two registers
  logic [15:0]      colour_table [PALETTE_DEPTH];
  pixel_mode_e      mode_now;
  logic [CNT_W-1:0] count_now;

  // colours the block still owes, oldest first
  out_t colours_due_q[$];

  // raw {stp, b, g, r} to rgb5a1, alpha set when "all black" matches stp
  function automatic logic [15:0] rgb5a1_of(input logic [15:0] raw);
    logic [4:0] red;
    logic [4:0] green;
    logic [4:0] blue;
    logic       rgb_zero;
    red      = raw[4:0];
    green    = raw[9:5];
    blue     = raw[14:10];
    rgb_zero = ((red | green | blue) == 5'd0);
    return {red, green, blue, rgb_zero ~^ raw[15]};
  endfunction

  task automatic queue_colour(input logic [15:0] colour, input logic err, input logic last);
    out_t res;
    res.pixel_colour = colour;
    res.index_error  = err;
    res.last_of_run  = last;
    colours_due_q.push_back(res);
  endtask

  // palette write or byte expansion for one accepted request
  task automatic predict_colours(input in_t req);
    int         limit;
    logic [7:0] lo_idx;
    logic [7:0] hi_idx;
    limit = (count_now > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(count_now);
    if (req.operation == OP_WRITE) begin
      if (req.entry_index < PALETTE_DEPTH) colour_table[req.entry_index] = req.entry_colour;
    end else if (mode_now == MODE_8BPP) begin
      if (req.pixel_byte >= limit) begin
        queue_colour(16'h0000, 1'b1, 1'b1);
      end else begin
        queue_colour(rgb5a1_of(colour_table[req.pixel_byte]), 1'b0, 1'b1);
      end
    end else begin
      // low nibble first; one bad nibble kills the whole byte
      lo_idx = {4'h0, req.pixel_byte[3:0]};
      hi_idx = {4'h0, req.pixel_byte[7:4]};
      if (lo_idx >= limit || hi_idx >= limit) begin
        queue_colour(16'h0000, 1'b1, 1'b1);
      end else begin
        queue_colour(rgb5a1_of(colour_table[lo_idx]), 1'b0, 1'b0);
        queue_colour(rgb5a1_of(colour_table[hi_idx]), 1'b0, 1'b1);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] %s: got %h, want %h", $time, what, got, want);
    mismatch_count_o++;
  endtask

  // snoop config and requests, compare results in order
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t want;
    if (!rst_ni) begin
      mode_now  = MODE_4BPP;
      count_now = '0;
      colours_due_q.delete();
      mismatch_count_o = 0;
      colours_owed_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PIXEL_MODE:    mode_now  = pixel_mode_e'(cfg_data_i[0]);
          CFG_PALETTE_COUNT: count_now = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_colours(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (colours_due_q.size() == 0) begin
          report_mismatch("result with nothing due", out_data_i.pixel_colour, 16'h0000);
        end else begin
          want = colours_due_q.pop_front();
          if (out_data_i.pixel_colour !== want.pixel_colour)
            report_mismatch("pixel_colour", out_data_i.pixel_colour, want.pixel_colour);
          if (out_data_i.index_error !== want.index_error)
            report_mismatch("index_error", {15'd0, out_data_i.index_error},
                            {15'd0, want.index_error});
          if (out_data_i.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", {15'd0, out_data_i.last_of_run},
                            {15'd0, want.last_of_run});
        end
      end
      colours_owed_o <= colours_due_q.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// testbench top for clut_pixel_expander_rgb5a1_core: clock, reset, stimulus and verdict
// depends on cpx_pkg, the block and cpx_checker
module testbench;
  import cpx_pkg::*;

  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_COUNT   = 12;
  localparam int PHASE_ITEMS   = 108;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  int                    mismatch_count;
  int                    colours_owed;

  // result-side controls, written by the stimulus with nonblocking assigns
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_served = 0;

  // stimulus-side view of the block, used to avoid reading unloaded entries
  int          sender_idle_pct = 0;
  pixel_mode_e cur_mode = MODE_4BPP;
  int          cur_count = 0;
  bit          entry_loaded [PALETTE_DEPTH];

  always #5 clk = ~clk;

  clut_pixel_expander_rgb5a1_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  cpx_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatch_count),
    .colours_owed_o   (colours_owed)
  );

  // result side: random stall, or one long hold-off when asked
  initial begin : result_side
    forever begin
      @(posedge clk);
      if (hold_req != hold_served) begin
        hold_served = hold_req;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // random junk in the fields the operation does not use
  function automatic in_t make_write(input int idx, input int colour);
    in_t req;
    int  junk;
    junk             = $urandom;
    req.operation    = OP_WRITE;
    req.pixel_byte   = junk[7:0];
    req.entry_index  = idx[7:0];
    req.entry_colour = colour[15:0];
    return req;
  endfunction

  function automatic in_t make_pixel(input int pix);
    in_t req;
    int  junk;
    junk             = $urandom;
    req.operation    = OP_PIXEL;
    req.pixel_byte   = pix[7:0];
    req.entry_index  = junk[23:16];
    req.entry_colour = junk[15:0];
    return req;
  endfunction

  // offer one request and hold it until the block takes it
  task automatic push_request(input in_t req);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load_entry(input int idx, input int colour);
    entry_loaded[idx] = 1'b1;
    push_request(make_write(idx, colour));
  endtask

  // drop valid, wait for every owed colour, then let the pipe drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (colours_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // both registers, back to back; mode data carries random upper bits
  task automatic apply_config(input pixel_mode_e m, input int cnt);
    int junk;
    junk = $urandom;
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_PIXEL_MODE;
    cfg_data <= {junk[7:0], m};
    @(posedge clk);
    cfg_idx  <= CFG_PALETTE_COUNT;
    cfg_data <= cnt[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_mode  = m;
    cur_count = cnt;
  endtask

  // random request; a byte that would read an unloaded entry becomes its write
  task automatic next_request(output in_t req);
    int limit;
    int top_nib;
    int pick;
    int lo_idx;
    int hi_idx;
    int miss;
    limit = (cur_count > PALETTE_DEPTH) ? PALETTE_DEPTH : cur_count;
    if ($urandom_range(99) < 15) begin
      pick = $urandom;
      if ($urandom_range(7) == 0) pick = pick & 32'h8000;
      req = make_write($urandom_range(PALETTE_DEPTH - 1), pick);
      entry_loaded[req.entry_index] = 1'b1;
    end else begin
      pick = $urandom_range(255);
      // mostly in-range bytes so lookups dominate
      if (limit > 0 && $urandom_range(99) < 75) begin
        if (cur_mode == MODE_8BPP) begin
          pick = $urandom_range(limit - 1);
        end else begin
          top_nib = (limit > 16) ? 15 : limit - 1;
          pick = ($urandom_range(top_nib) << 4) | $urandom_range(top_nib);
        end
      end
      req  = make_pixel(pick);
      miss = -1;
      if (cur_mode == MODE_8BPP) begin
        if (pick < limit && !entry_loaded[pick]) miss = pick;
      end else begin
        lo_idx = pick & 15;
        hi_idx = pick >> 4;
        if (lo_idx < limit && hi_idx < limit) begin
          if (!entry_loaded[lo_idx]) miss = lo_idx;
          else if (!entry_loaded[hi_idx]) miss = hi_idx;
        end
      end
      if (miss >= 0) begin
        req = make_write(miss, $urandom);
        entry_loaded[miss] = 1'b1;
      end
    end
  endtask

  initial begin : stimulus
    in_t         req;
    pixel_mode_e m;
    int          cnt;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: alpha corners, count zero, partial nibble errors, count extremes
    load_entry(0, 16'h0000);
    load_entry(1, 16'h8000);
    load_entry(2, 16'h7FFF);
    load_entry(15, 16'hFFFF);
    load_entry(255, 16'h8421);
    push_request(make_pixel(8'h00));
    apply_config(MODE_4BPP, 16);
    push_request(make_pixel(8'h10));
    push_request(make_pixel(8'hF2));
    push_request(make_pixel(8'h0F));
    apply_config(MODE_4BPP, 2);
    push_request(make_pixel(8'h10));
    push_request(make_pixel(8'h21));
    push_request(make_pixel(8'h02));
    apply_config(MODE_8BPP, 256);
    push_request(make_pixel(8'hFF));
    push_request(make_pixel(8'h00));
    push_request(make_pixel(8'h02));
    apply_config(MODE_8BPP, 511);
    push_request(make_pixel(8'hFF));
    apply_config(MODE_8BPP, 255);
    push_request(make_pixel(8'hFF));
    push_request(make_pixel(8'h0F));
    apply_config(MODE_8BPP, 0);
    push_request(make_pixel(8'h01));

    // random phases, each applying a setting and an idle profile
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0:       begin m = MODE_4BPP; cnt = 16;  end
        1:       begin m = MODE_8BPP; cnt = 256; end
        2:       begin m = MODE_8BPP; cnt = 511; end
        3:       begin m = MODE_4BPP; cnt = 5;   end
        4:       begin m = MODE_8BPP; cnt = 200; end
        5:       begin m = MODE_4BPP; cnt = 0;   end
        6:       begin m = MODE_8BPP; cnt = 1;   end
        7:       begin m = MODE_4BPP; cnt = 16;  end
        8:       begin m = MODE_8BPP; cnt = 256; end
        9:       begin m = MODE_4BPP; cnt = 16;  end
        default: begin
          m   = pixel_mode_e'($urandom_range(1));
          cnt = $urandom_range(511);
        end
      endcase
      apply_config(m, cnt);
      if (phase < 4) begin
        sender_idle_pct = 11;
        recv_idle_pct  <= 79;
      end else if (phase < 8) begin
        sender_idle_pct = 79;
        recv_idle_pct  <= 11;
      end else begin
        sender_idle_pct = 0;
        recv_idle_pct  <= 0;
      end
      // long result hold-off while requests keep coming
      if (phase == 9) hold_req <= hold_req + 1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        next_request(req);
        push_request(req);
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("[clut_pixel_expander_rgb5a1_core] OK");
    end else begin
      $display("[clut_pixel_expander_rgb5a1_core] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #5_000_000;
    $display("[clut_pixel_expander_rgb5a1_core] ERROR");
    $finish;
  end

endmodule
